// ===== rtl/core/b64sc_pkg.sv =====
package b64sc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION = 2'd0,
    REG_ALPHABET  = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               run_last;
    logic               stream_end;
    logic               no_data;
    logic [TOTAL_W-1:0] out_total;
  } out_item_t;

  // One queued transaction burst: up to four result bytes, first in lane 0.
  typedef struct packed {
    logic [3:0][7:0] lanes;
    logic [2:0]      cnt;
    logic            no_data;
    logic            eos;
  } job_t;

  function automatic logic [7:0] sym_to_char(input logic [5:0] v, input logic alph);
    logic [7:0] ve;
    ve = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + ve;
    end else if (v < 6'd52) begin
      return 8'h61 + ve - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + ve - 8'd52;
    end else if (v == 6'd62) begin
      return alph ? 8'h2D : 8'h2B;
    end else begin
      return alph ? 8'h5F : 8'h2F;
    end
  endfunction

  // Returns {valid, symbol}.
  function automatic logic [6:0] char_to_sym(input logic [7:0] c, input logic alph);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      return {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      return {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      return {1'b1, t[5:0]};
    end else if (c == (alph ? 8'h2D : 8'h2B)) begin
      return {1'b1, 6'd62};
    end else if (c == (alph ? 8'h5F : 8'h2F)) begin
      return {1'b1, 6'd63};
    end else begin
      return 7'd0;
    end
  endfunction

endpackage

// ===== rtl/core/b64sc_front.sv =====
module b64sc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [b64sc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b64sc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  b64sc_pkg::in_item_t              in_data,
  output logic                             job_valid,
  output b64sc_pkg::job_t                  job,
  input  logic                             job_ready
);
  import b64sc_pkg::*;

  logic        dir_r, dir_nxt;
  logic        alph_r, alph_nxt;
  logic [23:0] buf_r, buf_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        stop_r, stop_nxt;

  logic        accept;
  logic        has_job;
  logic [7:0]  b;
  logic        last;
  logic [23:0] g;
  logic [23:0] shifted;
  logic [2:0]  fill_up;
  logic [6:0]  sv;
  logic [23:0] d_buf;
  logic [1:0]  d_fill;

  assign in_stall = !job_ready;
  assign accept   = in_valid && job_ready;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;
  assign sv       = char_to_sym(b, alph_r);

  always_comb begin
    has_job  = 1'b0;
    job      = '0;
    job.eos  = last;
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    stop_nxt = stop_r;
    dir_nxt  = dir_r;
    alph_nxt = alph_r;
    g        = '0;
    shifted  = {buf_r[15:0], b};
    fill_up  = {1'b0, fill_r} + 3'd1;
    d_buf    = buf_r;
    d_fill   = fill_r;

    if (cfg_we) begin
      if (cfg_index == REG_DIRECTION) begin
        dir_nxt  = cfg_wdata[0];
        buf_nxt  = '0;
        fill_nxt = '0;
        stop_nxt = 1'b0;
      end else if (cfg_index == REG_ALPHABET) begin
        alph_nxt = cfg_wdata[0];
      end
    end else if (accept) begin
      if (dir_r == DIR_ENCODE) begin
        if (fill_r == 2'd2) begin
          has_job = 1'b1;
          job.cnt = 3'd4;
          for (int i = 0; i < 4; i++) begin
            job.lanes[i] = sym_to_char(shifted[18-6*i +: 6], alph_r);
          end
          buf_nxt  = '0;
          fill_nxt = '0;
        end else begin
          buf_nxt  = shifted;
          fill_nxt = fill_up[1:0];
          if (last) begin
            has_job = 1'b1;
            job.cnt = 3'd4;
            g = (fill_r == 2'd0) ? {b, 16'h0000} : {buf_r[7:0], b, 8'h00};
            for (int i = 0; i < 4; i++) begin
              if (3'(i) <= fill_up) begin
                job.lanes[i] = sym_to_char(g[18-6*i +: 6], alph_r);
              end else begin
                job.lanes[i] = PAD_CHAR;
              end
            end
          end
        end
      end else begin
        if (!stop_r) begin
          if (!sv[6]) begin
            stop_nxt = 1'b1;
          end else if (fill_r == 2'd3) begin
            g            = {buf_r[17:0], sv[5:0]};
            has_job      = 1'b1;
            job.cnt      = 3'd3;
            job.lanes[0] = g[23:16];
            job.lanes[1] = g[15:8];
            job.lanes[2] = g[7:0];
            d_buf        = '0;
            d_fill       = '0;
          end else begin
            d_buf  = {buf_r[17:0], sv[5:0]};
            d_fill = fill_r + 2'd1;
          end
        end
        buf_nxt  = d_buf;
        fill_nxt = d_fill;
        if (last) begin
          if (d_fill >= 2'd2) begin
            g            = (d_fill == 2'd2) ? {d_buf[11:0], 12'h000} : {d_buf[17:0], 6'h00};
            has_job      = 1'b1;
            job.cnt      = {1'b0, d_fill - 2'd1};
            job.lanes[0] = g[23:16];
            job.lanes[1] = g[15:8];
          end
          if (!has_job) begin
            has_job     = 1'b1;
            job.cnt     = 3'd1;
            job.no_data = 1'b1;
          end
        end
      end
      if (last) begin
        buf_nxt  = '0;
        fill_nxt = '0;
        stop_nxt = 1'b0;
      end
    end
  end

  assign job_valid = accept && has_job && !cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      alph_r <= 1'b0;
      buf_r  <= '0;
      fill_r <= '0;
      stop_r <= 1'b0;
    end else begin
      dir_r  <= dir_nxt;
      alph_r <= alph_nxt;
      buf_r  <= buf_nxt;
      fill_r <= fill_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ===== rtl/core/b64sc_fifo.sv =====
module b64sc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64sc_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output b64sc_pkg::job_t head
);
  import b64sc_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/b64sc_back.sv =====
module b64sc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 job_avail,
  input  b64sc_pkg::job_t      job,
  output logic                 job_pop,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b64sc_pkg::out_item_t out_data
);
  import b64sc_pkg::*;

  job_t                   cur_r, cur_nxt;
  logic                   cur_v_r, cur_v_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   out_v_r, out_v_nxt;
  out_item_t              out_r, out_nxt;

  logic                   adv;
  logic                   job_end;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [63:0]            cnt_ext;

  assign adv     = cur_v_r && (!out_v_r || !out_stall);
  assign job_end = ({1'b0, idx_r} == (cur_r.cnt - 3'd1));
  assign job_pop = job_avail && (!cur_v_r || (adv && job_end));
  assign busy    = cur_v_r;

  always_comb begin
    cnt_inc = cnt_r;
    if (!cur_r.no_data && (cnt_r != '1)) begin
      cnt_inc = cnt_r + COUNT_WIDTH'(1);
    end
    cnt_ext = 64'(cnt_inc);
  end

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r && out_stall;
    if (adv) begin
      out_v_nxt          = 1'b1;
      out_nxt.out_byte   = cur_r.no_data ? 8'h00 : cur_r.lanes[idx_r];
      out_nxt.run_last   = job_end;
      out_nxt.stream_end = job_end && cur_r.eos;
      out_nxt.no_data    = cur_r.no_data;
      out_nxt.out_total  = (cnt_ext > 64'hFFFF_FFFF) ? '1 : cnt_ext[TOTAL_W-1:0];
      cnt_nxt            = (job_end && cur_r.eos) ? '0 : cnt_inc;
      idx_nxt            = job_end ? 2'd0 : idx_r + 2'd1;
      if (job_end) begin
        cur_v_nxt = 1'b0;
      end
    end
    if (job_pop) begin
      cur_nxt   = job;
      cur_v_nxt = 1'b1;
    end
    if (clr) begin
      cnt_nxt = '0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

// ===== rtl/core/base64_stream_codec_unit.sv =====
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall   | in_item_t (in_byte, in_last)
// out_    | output    | out_valid/out_stall | out_item_t (byte, flags, out_total)
// cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// The front stage takes one input transaction per cycle while in_stall is low and pushes a
// burst of up to four results into a four-entry queue; the back stage drains one result
// per cycle while out_stall is low and a job is queued. Encoding is bounded by the single
// output port: four results per three bytes. Decoding sustains one character per cycle.
// Reset is synchronous and clears all control state; there is no clearing pass.
// in_stall rises only when the queue is full; out_stall holds the output register.
module base64_stream_codec_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [b64sc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b64sc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  b64sc_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output b64sc_pkg::out_item_t             out_data
);
  import b64sc_pkg::*;

  logic job_valid;
  job_t job;
  logic fifo_full;
  logic fifo_empty;
  logic job_pop;
  job_t head;
  logic back_busy;
  logic dir_clr;

  assign dir_clr = cfg_we && (cfg_index == REG_DIRECTION);

  b64sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (!fifo_full)
  );

  b64sc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (job),
    .full      (fifo_full),
    .pop       (job_pop),
    .empty     (fifo_empty),
    .head      (head)
  );

  b64sc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (dir_clr),
    .job_avail (!fifo_empty),
    .job       (head),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_nodata_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_data |->
      out_data.run_last && out_data.stream_end && (out_data.out_byte == 8'h00))
    else $error("no_data result does not close the stream");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last)
    else $error("stream_end without run_last");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_last |=> out_valid || back_busy)
    else $error("result burst ended before its last transaction");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !fifo_full)
    else $error("queue push while full");

endmodule
